[src/smv_pkg.sv]
// ----------------------------------------------------------------------------
// smv_pkg: shared types and constants for the symmetric sparse matvec block
// Word layouts of the input and result channels, mode codes and store sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package smv_pkg;

	// store depth and address width
	localparam int MAX_LENGTH = 1024;
	localparam int ADDR_W     = $clog2(MAX_LENGTH);

	// fixed field widths
	localparam int IDX_W  = 10;
	localparam int LEN_W  = 11;
	localparam int VAL_W  = 32;
	localparam int ACC_W  = 48;
	localparam int FRAC_W = 16;
	localparam int PROD_W = 2 * VAL_W;

	// length in force after reset
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

	// item modes
	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_OFFDIAG = 2'd1,
		MODE_DIAG    = 2'd2,
		MODE_READ    = 2'd3
	} mode_t;

	// input word
	typedef struct packed {
		mode_t                     mode;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		logic signed [VAL_W-1:0]   value;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [IDX_W-1:0]          result_index;
		logic signed [ACC_W-1:0]   result_value;
	} out_word_t;

endpackage

`default_nettype wire

[src/symmetric_sparse_matvec.sv]
// ----------------------------------------------------------------------------
// symmetric_sparse_matvec: symmetric sparse matrix times dense vector
// Coordinate entries of the upper triangle and diagonal are accumulated into
// a 48-bit saturating result store; results are read back word by word.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, in_word) takes one word at a
// time: load a vector element (clears its result word), an off-diagonal
// entry, a diagonal entry, or a read of one result word. Only a read that is
// in range returns a word on the output channel (out_valid, out_stall,
// out_word). cfg_we with cfg_data sets the vector length; the user writes it
// only while idle, the block does not enforce this. Words out of range are
// dropped at accept. A load writes in S_LOAD; an entry passes S_RD1, S_MUL1,
// S_ACC1 and if off-diagonal S_RD2, S_ACC2; a read passes S_READ and S_OUT.
// The steps come from each store's single read port and the one multiplier
// and saturating adder shared by both updates of an entry; in_stall is high
// while a word is at work. Results leave through an output register, so a
// new word is taken while a result waits; a further read waits until that
// register is free. After reset the result store is swept to zero, one word
// per cycle, with in_stall high; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module symmetric_sparse_matvec (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire smv_pkg::in_word_t                 in_word,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output smv_pkg::out_word_t                     out_word,
	input  wire logic                              cfg_we,
	input  wire logic [smv_pkg::LEN_W-1:0]         cfg_data
);

	// sequencer states
	typedef enum logic [9:0] {
		S_CLEAR = 10'b00_0000_0001,
		S_IDLE  = 10'b00_0000_0010,
		S_LOAD  = 10'b00_0000_0100,
		S_RD1   = 10'b00_0000_1000,
		S_MUL1  = 10'b00_0001_0000,
		S_ACC1  = 10'b00_0010_0000,
		S_RD2   = 10'b00_0100_0000,
		S_ACC2  = 10'b00_1000_0000,
		S_READ  = 10'b01_0000_0000,
		S_OUT   = 10'b10_0000_0000
	} state_t;

	state_t                               state_q, state_d;
	logic [smv_pkg::ADDR_W-1:0]           clr_q;
	logic [smv_pkg::LEN_W-1:0]            len_q;
	logic [smv_pkg::LEN_W-1:0]            len_eff;
	smv_pkg::in_word_t                    item_q;
	logic                                 accept;
	logic                                 row_ok, col_ok;
	logic                                 out_free;
	logic                                 out_valid_q;
	smv_pkg::out_word_t                   out_word_q;

	logic                                 vram_we, vram_re;
	logic [smv_pkg::ADDR_W-1:0]           vram_waddr, vram_raddr;
	logic [smv_pkg::VAL_W-1:0]            vram_rdata;
	logic                                 rram_we, rram_re;
	logic [smv_pkg::ADDR_W-1:0]           rram_waddr, rram_raddr;
	logic [smv_pkg::ACC_W-1:0]            rram_wdata, rram_rdata;

	logic signed [smv_pkg::PROD_W-1:0]    product;
	logic signed [smv_pkg::ACC_W-1:0]     term_q;
	logic signed [smv_pkg::ACC_W:0]       sum_wide;
	logic signed [smv_pkg::ACC_W-1:0]     sum_sat;

	// handshake
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// range check against the effective length
	assign len_eff = (len_q > smv_pkg::LEN_W'(smv_pkg::MAX_LENGTH))
		? smv_pkg::LEN_W'(smv_pkg::MAX_LENGTH) : len_q;
	assign row_ok  = smv_pkg::LEN_W'(in_word.row) < len_eff;
	assign col_ok  = smv_pkg::LEN_W'(in_word.col) < len_eff;

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= smv_pkg::LEN_RESET;
		end else if (cfg_we) begin
			len_q <= cfg_data;
		end
	end

	// captured word
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_word;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == smv_pkg::ADDR_W'(smv_pkg::MAX_LENGTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					case (in_word.mode)
						smv_pkg::MODE_LOAD:    state_d = row_ok ? S_LOAD : S_IDLE;
						smv_pkg::MODE_OFFDIAG: state_d = (row_ok && col_ok) ? S_RD1 : S_IDLE;
						smv_pkg::MODE_DIAG:    state_d = (row_ok && col_ok) ? S_RD1 : S_IDLE;
						smv_pkg::MODE_READ:    state_d = row_ok ? S_READ : S_IDLE;
						default:               state_d = S_IDLE;
					endcase
				end
			end
			S_LOAD:  state_d = S_IDLE;
			S_RD1:   state_d = S_MUL1;
			S_MUL1:  state_d = S_ACC1;
			S_ACC1: begin
				state_d = (item_q.mode == smv_pkg::MODE_OFFDIAG) ? S_RD2 : S_IDLE;
			end
			S_RD2:   state_d = S_ACC2;
			S_ACC2:  state_d = S_IDLE;
			S_READ:  state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// vector store port control
	assign vram_we    = (state_q == S_LOAD);
	assign vram_waddr = smv_pkg::ADDR_W'(item_q.row);
	assign vram_re    = (state_q == S_RD1) || (state_q == S_MUL1);
	assign vram_raddr = (state_q == S_RD1) ? smv_pkg::ADDR_W'(item_q.col)
		: smv_pkg::ADDR_W'(item_q.row);

	smv_ram #(
		.WIDTH (smv_pkg::VAL_W),
		.DEPTH (smv_pkg::MAX_LENGTH)
	) u_vram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (vram_waddr),
		.wdata (item_q.value),
		.re    (vram_re),
		.raddr (vram_raddr),
		.rdata (vram_rdata)
	);

	// shared multiplier, product truncated toward minus infinity
	assign product = item_q.value * $signed(vram_rdata);

	always_ff @(posedge clk) begin
		if ((state_q == S_MUL1) || (state_q == S_ACC1)) begin
			term_q <= product[smv_pkg::FRAC_W +: smv_pkg::ACC_W];
		end
	end

	// shared saturating accumulator
	assign sum_wide = {rram_rdata[smv_pkg::ACC_W-1], rram_rdata}
		+ {term_q[smv_pkg::ACC_W-1], term_q};

	always_comb begin
		if (sum_wide[smv_pkg::ACC_W] != sum_wide[smv_pkg::ACC_W-1]) begin
			sum_sat = sum_wide[smv_pkg::ACC_W]
				? {1'b1, {(smv_pkg::ACC_W-1){1'b0}}}
				: {1'b0, {(smv_pkg::ACC_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[smv_pkg::ACC_W-1:0];
		end
	end

	// result store port control
	assign rram_we = (state_q == S_CLEAR) || (state_q == S_LOAD)
		|| (state_q == S_ACC1) || (state_q == S_ACC2);

	always_comb begin
		case (state_q)
			S_CLEAR: rram_waddr = clr_q;
			S_ACC2:  rram_waddr = smv_pkg::ADDR_W'(item_q.col);
			default: rram_waddr = smv_pkg::ADDR_W'(item_q.row);
		endcase
	end

	assign rram_wdata = ((state_q == S_CLEAR) || (state_q == S_LOAD)) ? '0 : sum_sat;
	assign rram_re    = (state_q == S_RD1) || (state_q == S_RD2) || (state_q == S_READ);
	assign rram_raddr = (state_q == S_RD2) ? smv_pkg::ADDR_W'(item_q.col)
		: smv_pkg::ADDR_W'(item_q.row);

	smv_ram #(
		.WIDTH (smv_pkg::ACC_W),
		.DEPTH (smv_pkg::MAX_LENGTH)
	) u_rram (
		.clk   (clk),
		.we    (rram_we),
		.waddr (rram_waddr),
		.wdata (rram_wdata),
		.re    (rram_re),
		.raddr (rram_raddr),
		.rdata (rram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			out_word_q.result_index <= item_q.row;
			out_word_q.result_value <= $signed(rram_rdata);
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// checks
	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result word raised outside the read sequence");

	a_read_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_word.mode == smv_pkg::MODE_READ && row_ok) |=> (state_q == S_READ))
		else $error("in-range read did not start a store read");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (in_stall && rram_we && rram_wdata == '0))
		else $error("clearing sweep not writing zero or not stalling input");

	a_offdiag_second: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC1 && item_q.mode == smv_pkg::MODE_OFFDIAG) |=> (state_q == S_RD2))
		else $error("off-diagonal entry skipped its mirrored update");

endmodule

`default_nettype wire

[src/smv_ram.sv]
// ----------------------------------------------------------------------------
// smv_ram: generic simple dual-port RAM
// One write port and one read port, read data registered and held while
// the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module smv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[tb/smv_result_checker.sv]
// ----------------------------------------------------------------------------
// smv_result_checker: result predictor and comparator for symmetric_sparse_matvec
// Watches the input, result and configuration ports. Every accepted input
// word is applied to a local copy of the vector store, the result store and
// the length. In-range reads queue the word that should come back. Each
// accepted result word is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module smv_result_checker
	import smv_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire in_word_t          in_word,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire out_word_t         out_word,
	input  wire logic              cfg_we,
	input  wire logic [LEN_W-1:0]  cfg_data,
	output int                     mismatches,
	output int                     results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;

	// local copy of the block's state
	logic signed [VAL_W-1:0] x_model [MAX_LENGTH];
	logic signed [ACC_W-1:0] y_model [MAX_LENGTH];
	logic [LEN_W-1:0]        length_reg;
	out_word_t               reads_due [$];
	int                      fails;

	// q16.16 times q16.16, low fraction bits dropped toward minus infinity
	function automatic longint scaled_product(logic signed [VAL_W-1:0] a,
			logic signed [VAL_W-1:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return p >>> FRAC_W;
	endfunction

	// 48-bit accumulate with clamping at both ends
	function automatic logic signed [ACC_W-1:0] add_clamped(logic signed [ACC_W-1:0] acc,
			longint term);
		longint sum;
		sum = longint'(acc) + term;
		if (sum > ACC_HI)
			sum = ACC_HI;
		else if (sum < ACC_LO)
			sum = ACC_LO;
		return sum[ACC_W-1:0];
	endfunction

	// apply one accepted word; an in-range read queues its result word
	function automatic void predict_word(in_word_t w);
		int unsigned lim, r, c;
		out_word_t   res;
		lim = (length_reg > MAX_LENGTH) ? MAX_LENGTH : int'(length_reg);
		r   = w.row;
		c   = w.col;
		case (w.mode)
			MODE_LOAD: begin
				if (r < lim) begin
					x_model[r] = w.value;
					y_model[r] = '0;
				end
			end
			MODE_OFFDIAG: begin
				// both halves in order, the second sees the first when row equals col
				if (r < lim && c < lim) begin
					y_model[r] = add_clamped(y_model[r], scaled_product(w.value, x_model[c]));
					y_model[c] = add_clamped(y_model[c], scaled_product(w.value, x_model[r]));
				end
			end
			MODE_DIAG: begin
				if (r < lim && c < lim)
					y_model[r] = add_clamped(y_model[r], scaled_product(w.value, x_model[c]));
			end
			default: begin
				if (r < lim) begin
					res.result_index = w.row;
					res.result_value = y_model[r];
					reads_due = {reads_due, res};
				end
			end
		endcase
	endfunction

	// compare result words first, then take new input and config words
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			foreach (y_model[i])
				y_model[i] = '0;
			length_reg = LEN_RESET;
			reads_due.delete();
			fails = 0;
			mismatches  <= 0;
			results_due <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (reads_due.size() == 0) begin
					$error("result_index: expected no word, got %0d", out_word.result_index);
					fails++;
				end else begin
					want = reads_due.pop_front();
					if (out_word.result_index !== want.result_index) begin
						$error("result_index: expected %0d, got %0d",
							want.result_index, out_word.result_index);
						fails++;
					end
					if (out_word.result_value !== want.result_value) begin
						$error("result_value: expected %0d, got %0d",
							want.result_value, out_word.result_value);
						fails++;
					end
				end
			end
			// a word taken at the same edge as a length write still sees the old length
			if (in_valid && !in_stall)
				predict_word(in_word);
			if (cfg_we)
				length_reg = cfg_data;
			mismatches  <= fails;
			results_due <= reads_due.size();
		end
	end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: regression for symmetric_sparse_matvec
// Directed words hit the value extremes, both saturation limits, truncation
// of negative products, row equal to col, out-of-range indices and zero
// length. Random phases then run well-formed load, entry and read words over
// several lengths, with random source gaps and result stalls, and a closing
// phase at full rate. Results are checked by smv_result_checker.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import smv_pkg::*;

	localparam int PHASE_WORDS    = 250;
	localparam int PHASE_LENS [7] = '{2047, 1, 5, 64, 1024, 200, 1024};
	localparam int SETTLE_CYCLES  = 12;
	localparam int CYCLE_LIMIT    = 500000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_word_t         in_word;
	logic             out_valid;
	logic             out_stall;
	out_word_t        out_word;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_data;
	int               mismatches;
	int               results_due;

	// stimulus state
	bit          loaded [MAX_LENGTH];
	int unsigned cur_len = MAX_LENGTH;
	bit          idle_on = 1'b1;
	int          gap_pct = 20;
	int          words_sent;
	int          reads_sent;
	int          lengths_used = 1;

	symmetric_sparse_matvec i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	smv_result_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.results_due (results_due)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// value mix: extremes, full random, small magnitudes that rarely clamp
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0:       return 32'h7fff_ffff;
					1:       return 32'h8000_0000;
					2:       return '0;
					default: return '1;
				endcase
			end
			1, 2, 3, 4: return $urandom();
			default:    return VAL_W'($urandom_range(0, 1 << 19) - (1 << 18));
		endcase
	endfunction

	// hand one word over, with an optional gap in front of it
	task automatic send_word(mode_t m, int unsigned r, int unsigned c, logic [VAL_W-1:0] v);
		in_word_t w;
		w.mode  = m;
		w.row   = IDX_W'(r);
		w.col   = IDX_W'(c);
		w.value = v;
		if (idle_on && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		if (m == MODE_LOAD && r < cur_len)
			loaded[r] = 1'b1;
		if (m == MODE_READ && r < cur_len)
			reads_sent++;
		if (words_sent % 40 == 0)
			gap_pct = idle_on ? 20 * $urandom_range(0, 2) : 0;
	endtask

	// wait until every read has returned and the last entry has finished
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_length(int unsigned len);
		settle();
		cfg_we   <= 1'b1;
		cfg_data <= LEN_W'(len);
		@(posedge clk);
		cfg_we   <= 1'b0;
		cur_len = (len > MAX_LENGTH) ? MAX_LENGTH : len;
		lengths_used++;
	endtask

	// one random word; only entries that touch an unloaded element are turned into loads
	task automatic random_word(output bit counted);
		int unsigned pick, r, c, t;
		mode_t       m;
		pick    = $urandom_range(0, 99);
		counted = 1'b1;
		if (pick < 10 && cur_len < MAX_LENGTH) begin
			// an index at or beyond the length: the block drops the word
			m = mode_t'($urandom_range(0, 3));
			r = $urandom_range(cur_len, MAX_LENGTH - 1);
			c = $urandom_range(0, MAX_LENGTH - 1);
			if ((m == MODE_OFFDIAG || m == MODE_DIAG) && $urandom_range(0, 1)) begin
				t = r;
				r = c;
				c = t;
			end
			counted = 1'b0;
			send_word(m, r, c, pick_value());
		end else begin
			r = $urandom_range(0, cur_len - 1);
			c = $urandom_range(0, cur_len - 1);
			if (pick < 35) begin
				send_word(MODE_LOAD, r, c, pick_value());
			end else if (pick < 60) begin
				if ($urandom_range(0, 7) == 0)
					c = r;
				if (!loaded[r])
					send_word(MODE_LOAD, r, c, pick_value());
				else if (!loaded[c])
					send_word(MODE_LOAD, c, r, pick_value());
				else
					send_word(MODE_OFFDIAG, r, c, pick_value());
			end else if (pick < 75) begin
				if ($urandom_range(0, 3) != 0)
					c = r;
				if (!loaded[c])
					send_word(MODE_LOAD, c, r, pick_value());
				else
					send_word(MODE_DIAG, r, c, pick_value());
			end else begin
				send_word(MODE_READ, r, c, pick_value());
			end
		end
	endtask

	// result side stalls in bursts, with calm stretches in between
	initial begin
		int stall_pct;
		int tick;
		stall_pct = 30;
		tick      = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (tick % 150 == 0)
				stall_pct = 10 * $urandom_range(0, 6);
			if (idle_on && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("symmetric_sparse_matvec regression: fail");
		$finish;
	end

	// stimulus and verdict
	initial begin
		int  done;
		bit  counted;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_word  <= '0;
		cfg_we   <= 1'b0;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset length: cleared store, extremes, clamping and truncation
		send_word(MODE_READ, 0, 0, '0);
		send_word(MODE_LOAD, 0, 0, 32'h8000_0000);
		send_word(MODE_LOAD, 1023, 0, 32'h7fff_ffff);
		send_word(MODE_LOAD, 5, 0, 32'h0001_0000);
		send_word(MODE_LOAD, 6, 0, 32'hffff_ffff);
		// two full-scale squares clamp at the top
		send_word(MODE_DIAG, 0, 0, 32'h8000_0000);
		send_word(MODE_DIAG, 0, 0, 32'h8000_0000);
		// row differs from col on a diagonal entry, three times to clamp at the bottom
		repeat (3) send_word(MODE_DIAG, 1023, 0, 32'h7fff_ffff);
		// tiny negative product rounds toward minus infinity
		send_word(MODE_OFFDIAG, 5, 6, 32'h0000_0001);
		// row equals col: both halves land on one word
		send_word(MODE_OFFDIAG, 5, 5, 32'h0001_0000);
		send_word(MODE_OFFDIAG, 0, 1023, 32'h8000_0000);
		send_word(MODE_READ, 0, 0, '0);
		send_word(MODE_READ, 1023, 0, '0);
		send_word(MODE_READ, 5, 0, '0);
		send_word(MODE_READ, 6, 0, '0);
		// a load clears its result word
		send_word(MODE_LOAD, 0, 0, 32'h7fff_ffff);
		send_word(MODE_READ, 0, 1023, '1);

		// indices at or past a short length are dropped
		set_length(16);
		send_word(MODE_LOAD, 20, 0, 32'h1234_5678);
		send_word(MODE_OFFDIAG, 3, 16, 32'h0001_0000);
		send_word(MODE_DIAG, 16, 2, 32'h0001_0000);
		send_word(MODE_READ, 16, 0, '0);

		// zero length drops everything
		set_length(0);
		send_word(MODE_READ, 0, 0, '0);
		send_word(MODE_LOAD, 0, 0, 32'h0002_0000);
		send_word(MODE_DIAG, 0, 0, 32'h0001_0000);

		// random phases, the last one at full rate on both sides
		foreach (PHASE_LENS[p]) begin
			idle_on = (p != $size(PHASE_LENS) - 1);
			if (!idle_on)
				gap_pct = 0;
			set_length(PHASE_LENS[p]);
			done = 0;
			while (done < PHASE_WORDS) begin
				random_word(counted);
				if (counted)
					done++;
			end
		end
		settle();

		$display("%0d words accepted over %0d length settings, %0d in-range reads checked",
			words_sent, lengths_used, reads_sent);
		if (mismatches == 0)
			$display("symmetric_sparse_matvec regression: pass");
		else
			$display("symmetric_sparse_matvec regression: fail");
		$finish;
	end

endmodule
